// ===== hdl/vlbp_pkg.sv =====
// Package for the variable-length bit packer: field widths, byte constants
// and queue sizing shared by the interfaces and all modules.
// No dependencies.
package vlbp_pkg;

   localparam int CODE_LEN_W       = 6;
   localparam int CODE_BITS_W      = 32;
   localparam int BYTE_W           = 8;
   localparam int MAX_CODE_LEN_DEF = 32;
   localparam int QUEUE_DEPTH      = 2;

   // Byte sent alone when a flush finds no pending bits.
   localparam logic [BYTE_W-1:0] EMPTY_FLUSH_BYTE = 8'h08;

   // Pending bits held between items (at most one byte less one bit).
   localparam int PEND_W  = BYTE_W - 1;
   localparam int PCNT_W  = 3;

endpackage

// ===== hdl/vlbp_req_if.sv =====
// Input channel of the bit packer: one code (length and bits) per beat.
// Depends on vlbp_pkg.
interface vlbp_req_if
   import vlbp_pkg::*;
   ();
   logic                   valid;
   logic                   ready;
   logic [CODE_LEN_W-1:0]  code_len;
   logic [CODE_BITS_W-1:0] code_bits;

   modport source (output valid, output code_len, output code_bits, input ready);
   modport sink   (input valid, input code_len, input code_bits, output ready);
endinterface

// ===== hdl/vlbp_rsp_if.sv =====
// Output channel of the bit packer: one packed byte and a last flag per beat.
// Depends on vlbp_pkg.
interface vlbp_rsp_if
   import vlbp_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last;

   modport source (output valid, output out_byte, output last, input ready);
   modport sink   (input valid, input out_byte, input last, output ready);
endinterface

// ===== hdl/vlbp_front.sv =====
// Front end of the bit packer: accepts codes, merges them with the pending
// bits and hands complete bytes to the queue as one job. Depends on vlbp_pkg.
module vlbp_front
   import vlbp_pkg::*;
#(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF,
   parameter int DATA_W       = 39,
   parameter int POS_W        = 6
) (
   input  logic              clock,
   input  logic              reset,
   vlbp_req_if.sink          req_ch,
   output logic              job_valid,
   input  logic              job_ready,
   output logic [DATA_W-1:0] job_data,
   output logic [POS_W-1:0]  job_pos
);

   localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

   logic [PEND_W-1:0]      acc_ff, acc_in;
   logic [PCNT_W-1:0]      cnt_ff, cnt_in;
   logic [LEN_W-1:0]       len_sat;
   logic [CODE_BITS_W-1:0] bits_msk;
   logic [DATA_W-1:0]      merged;
   logic [POS_W-1:0]       total;
   logic [BYTE_W-1:0]      flush_head;
   logic                   is_flush;
   logic                   accept;

   assign req_ch.ready = job_ready;
   assign accept       = req_ch.valid && job_ready;
   assign is_flush     = (req_ch.code_len == '0);

   always_comb begin
      if (req_ch.code_len > CODE_LEN_W'(MAX_CODE_LEN)) begin
         len_sat = LEN_W'(MAX_CODE_LEN);
      end else begin
         len_sat = req_ch.code_len[LEN_W-1:0];
      end
      bits_msk   = req_ch.code_bits & ~({CODE_BITS_W{1'b1}} << len_sat);
      merged     = (DATA_W'(acc_ff) << len_sat) | DATA_W'(bits_msk);
      total      = POS_W'(cnt_ff) + POS_W'(len_sat);
      flush_head = BYTE_W'({acc_ff, 1'b0} << (PCNT_W'(PEND_W) - cnt_ff));
   end

   // A flush is packaged as a generic job so the back end needs no special case.
   always_comb begin
      job_valid = 1'b0;
      job_data  = merged;
      job_pos   = total;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      if (is_flush) begin
         if (cnt_ff != '0) begin
            job_data = DATA_W'({flush_head, BYTE_W'(cnt_ff)});
            job_pos  = POS_W'(2 * BYTE_W);
         end else begin
            job_data = DATA_W'(EMPTY_FLUSH_BYTE);
            job_pos  = POS_W'(BYTE_W);
         end
         job_valid = req_ch.valid;
         if (accept) begin
            acc_in = '0;
            cnt_in = '0;
         end
      end else begin
         job_valid = req_ch.valid && (total >= POS_W'(BYTE_W));
         if (accept) begin
            cnt_in = total[PCNT_W-1:0];
            acc_in = merged[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[PCNT_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef ASSERT_OFF
   a_acc_clean: assert property (@(posedge clock) disable iff (reset)
      (acc_ff & ({PEND_W{1'b1}} << cnt_ff)) == '0)
      else $error("pending bits above the count are not zero");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      accept && is_flush |=> (acc_ff == '0) && (cnt_ff == '0))
      else $error("state not cleared after a flush");
`endif

endmodule

// ===== hdl/vlbp_queue.sv =====
// Short job queue between the front and back ends of the bit packer.
// Depends on vlbp_pkg for its depth.
module vlbp_queue
   import vlbp_pkg::*;
#(
   parameter int DATA_W = 39,
   parameter int POS_W  = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   input  logic [POS_W-1:0]  push_pos,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data,
   output logic [POS_W-1:0]  pop_pos
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] data_mem [QUEUE_DEPTH];
   logic [POS_W-1:0]  pos_mem  [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = data_mem[rd_ptr_ff];
   assign pop_pos    = pos_mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_mem[wr_ptr_ff] <= push_data;
         pos_mem[wr_ptr_ff]  <= push_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond its depth");
`endif

endmodule

// ===== hdl/vlbp_back.sv =====
// Back end of the bit packer: takes jobs from the queue and sends their
// complete bytes, most significant first, one per beat. Depends on vlbp_pkg.
module vlbp_back
   import vlbp_pkg::*;
#(
   parameter int DATA_W = 39,
   parameter int POS_W  = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_valid,
   output logic              job_ready,
   input  logic [DATA_W-1:0] job_data,
   input  logic [POS_W-1:0]  job_pos,
   vlbp_rsp_if.source        rsp_ch
);

   logic              busy_ff, busy_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              out_free;
   logic              emit;
   logic              final_byte;

   assign out_free   = !valid_ff || rsp_ch.ready;
   assign emit       = busy_ff && out_free;
   // Fewer than two bytes left at the cursor means this byte ends the job.
   assign final_byte = (pos_ff < POS_W'(2 * BYTE_W));
   assign job_ready  = !busy_ff || (emit && final_byte);

   always_comb begin
      busy_in  = busy_ff;
      data_in  = data_ff;
      pos_in   = pos_ff;
      valid_in = valid_ff && !rsp_ch.ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = BYTE_W'(data_ff >> (pos_ff - POS_W'(BYTE_W)));
         last_in  = final_byte;
         pos_in   = pos_ff - POS_W'(BYTE_W);
         busy_in  = !final_byte;
      end
      if (job_valid && job_ready) begin
         busy_in = 1'b1;
         data_in = job_data;
         pos_in  = job_pos;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      pos_ff  <= pos_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_ch.valid    = valid_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.last     = last_ff;

`ifndef ASSERT_OFF
   a_busy_has_byte: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> pos_ff >= POS_W'(BYTE_W))
      else $error("active job without a complete byte");
`endif

endmodule

// ===== hdl/variable_length_bit_packer_core.sv =====
// MSB-first variable-length bit packer, top level.
// req_ch carries one code per beat: code_len (0 = flush) and right-aligned
// code_bits. Lengths above MAX_CODE_LEN are treated as MAX_CODE_LEN.
// rsp_ch carries packed bytes, first bit in the MSB; last marks the final
// byte that one input beat causes. A code that completes no byte gives no
// beat. A flush gives the left-aligned partial byte and then the count of
// its valid bits, or the single byte 8 when nothing is pending.
// An accepted code passes through the job queue, the back-end job register
// and the output register before its first byte appears. While the receiver
// is ready, one output byte leaves per cycle, up to four for a 32-bit code;
// the byte emitter in the back end sets that rate. A two-entry job queue
// lets the front keep accepting codes while the back end drains bytes.
// When the receiver stalls, the output register holds its byte, the queue
// fills and req_ch.ready drops. Reset (synchronous) clears the pending
// bits, the queue and the output register; no clearing pass is needed.
// Depends on vlbp_pkg, vlbp_req_if, vlbp_rsp_if and the vlbp_* modules.
module variable_length_bit_packer_core
   import vlbp_pkg::*;
#(
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   vlbp_req_if.sink    req_ch,
   vlbp_rsp_if.source  rsp_ch
);

   // Widest job: pending bits plus one code, or the two bytes of a flush.
   localparam int DATA_W = (MAX_CODE_LEN + PEND_W > 2 * BYTE_W) ?
                           (MAX_CODE_LEN + PEND_W) : (2 * BYTE_W);
   localparam int POS_W  = $clog2(DATA_W + 1);

   logic              fj_valid, fj_ready;
   logic [DATA_W-1:0] fj_data;
   logic [POS_W-1:0]  fj_pos;
   logic              bj_valid, bj_ready;
   logic [DATA_W-1:0] bj_data;
   logic [POS_W-1:0]  bj_pos;

   vlbp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .DATA_W       (DATA_W),
      .POS_W        (POS_W)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .job_valid (fj_valid),
      .job_ready (fj_ready),
      .job_data  (fj_data),
      .job_pos   (fj_pos)
   );

   vlbp_queue #(
      .DATA_W (DATA_W),
      .POS_W  (POS_W)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fj_valid),
      .push_ready (fj_ready),
      .push_data  (fj_data),
      .push_pos   (fj_pos),
      .pop_valid  (bj_valid),
      .pop_ready  (bj_ready),
      .pop_data   (bj_data),
      .pop_pos    (bj_pos)
   );

   vlbp_back #(
      .DATA_W (DATA_W),
      .POS_W  (POS_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (bj_valid),
      .job_ready (bj_ready),
      .job_data  (bj_data),
      .job_pos   (bj_pos),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== tb/vlbp_byte_checker.sv =====
// Scoreboard for the variable-length bit packer: predicts the packed bytes
// of every accepted code and compares them with the bytes that leave rsp_ch.
// Depends on vlbp_pkg, vlbp_req_if and vlbp_rsp_if.
module vlbp_byte_checker
   import vlbp_pkg::*;
(
   input  logic clock,
   input  logic reset,
   vlbp_req_if  req_mon,
   vlbp_rsp_if  rsp_mon,
   output int   fail_count,
   output int   bytes_pending,
   output int   bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 100;

   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              last;
   } packed_byte_type;

   packed_byte_type   expected_bytes[$];
   logic [PEND_W-1:0] held_bits;
   logic [PCNT_W-1:0] held_count;

   task automatic report_failure(input string msg);
      if (fail_count < REPORT_LIMIT) begin
         $display("%0t ns: %s", $time, msg);
      end else if (fail_count == REPORT_LIMIT) begin
         $display("%0t ns: further mismatch reports suppressed", $time);
      end
      fail_count++;
   endtask

   function automatic void expect_byte(input logic [BYTE_W-1:0] value, input logic last);
      packed_byte_type entry;
      entry.value = value;
      entry.last  = last;
      expected_bytes.push_back(entry);
   endfunction

   // Appends one code to the held bits and queues every byte it completes.
   function automatic void pack_code(input logic [CODE_LEN_W-1:0]  len_in,
                                     input logic [CODE_BITS_W-1:0] bits_in);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] aligned;
      int unsigned       nbits;
      int unsigned       fill;
      int unsigned       made;
      acc  = BYTE_W'(held_bits);
      fill = held_count;
      made = 0;
      if (len_in == '0) begin
         if (fill != 0) begin
            aligned = acc << (BYTE_W - fill);
            expect_byte(aligned, 1'b0);
            expect_byte(BYTE_W'(fill), 1'b1);
         end else begin
            expect_byte(EMPTY_FLUSH_BYTE, 1'b1);
         end
         held_bits  = '0;
         held_count = '0;
         return;
      end
      nbits = (len_in > MAX_CODE_LEN_DEF) ? MAX_CODE_LEN_DEF : len_in;
      for (int i = int'(nbits) - 1; i >= 0; i--) begin
         acc = {acc[BYTE_W-2:0], bits_in[i]};
         fill++;
         if (fill == BYTE_W) begin
            expect_byte(acc, 1'b0);
            made++;
            acc  = '0;
            fill = 0;
         end
      end
      if (made != 0) begin
         expected_bytes[expected_bytes.size() - 1].last = 1'b1;
      end
      held_bits  = acc[PEND_W-1:0];
      held_count = PCNT_W'(fill);
   endfunction

   always @(posedge clock) begin
      packed_byte_type want;
      if (reset) begin
         expected_bytes.delete();
         held_bits  = '0;
         held_count = '0;
      end else begin
         // A byte leaving in this cycle always belongs to an earlier code,
         // so queuing the new code first does not disturb the order.
         if (req_mon.valid && req_mon.ready) begin
            pack_code(req_mon.code_len, req_mon.code_bits);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_bytes.size() == 0) begin
               report_failure($sformatf("unexpected beat out_byte=%02h last=%0b",
                                        rsp_mon.out_byte, rsp_mon.last));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_mon.out_byte !== want.value) begin
                  report_failure($sformatf("out_byte expected %02h, got %02h",
                                           want.value, rsp_mon.out_byte));
               end
               if (rsp_mon.last !== want.last) begin
                  report_failure($sformatf("last expected %0b, got %0b (out_byte %02h)",
                                           want.last, rsp_mon.last, want.value));
               end
               bytes_checked++;
            end
         end
      end
      bytes_pending <= expected_bytes.size();
   end

endmodule

// ===== tb/tb_variable_length_bit_packer_core.sv =====
// Testbench top for variable_length_bit_packer_core: clock, reset, code
// stimulus with bursty sending and receiver stalls, and the final verdict.
// Depends on vlbp_pkg, both channel interfaces, the core and vlbp_byte_checker.
module tb_variable_length_bit_packer_core;
   import vlbp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_CODES = 380;
   localparam int TAIL_CYCLES  = 20;

   typedef enum int {
      RX_ALWAYS,
      RX_RANDOM,
      RX_ONE_IN_FOUR,
      RX_LONG_STALLS
   } stall_mode_type;

   logic clock;
   logic reset;

   int mismatches;
   int bytes_left;
   int bytes_seen;
   int codes_sent;
   int flushes_sent;
   int overlong_sent;
   int burst_left;

   vlbp_req_if req_ch ();
   vlbp_rsp_if rsp_ch ();

   variable_length_bit_packer_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   vlbp_byte_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (mismatches),
      .bytes_pending (bytes_left),
      .bytes_checked (bytes_seen)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Sends one code, opening a new burst after a random gap when the
   // current one is used up. Valid stays high after the beat so that
   // back-to-back codes follow without a gap.
   task automatic send_code(input logic [CODE_LEN_W-1:0]  len,
                            input logic [CODE_BITS_W-1:0] bits);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 10);
      end
      req_ch.valid     <= 1'b1;
      req_ch.code_len  <= len;
      req_ch.code_bits <= bits;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
      codes_sent++;
      if (len == '0) flushes_sent++;
      if (len > MAX_CODE_LEN_DEF) overlong_sent++;
   endtask

   // Holds the sender off until every predicted byte has left the block.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (bytes_left != 0);
   endtask

   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             run_left;
      logic           level;
      mode      = RX_ALWAYS;
      mode_left = 0;
      run_left  = 0;
      level     = 1'b1;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 150);
         end
         mode_left--;
         unique case (mode)
            RX_ALWAYS: begin
               rsp_ch.ready <= 1'b1;
            end
            RX_RANDOM: begin
               rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            end
            RX_ONE_IN_FOUR: begin
               rsp_ch.ready <= (mode_left % 4 == 0);
            end
            default: begin
               if (run_left == 0) begin
                  level    = !level;
                  run_left = level ? $urandom_range(1, 5) : $urandom_range(1, 20);
               end
               run_left--;
               rsp_ch.ready <= level;
            end
         endcase
      end
   end

   initial begin
      int                     pick;
      logic [CODE_LEN_W-1:0]  len;
      logic [CODE_BITS_W-1:0] bits;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.code_len  = '0;
      req_ch.code_bits = '0;
      burst_left       = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Flush with nothing pending, then partial bytes of one and seven bits.
      send_code(6'd0, 32'h0000_0000);
      send_code(6'd1, 32'h0000_0001);
      send_code(6'd0, 32'h0000_0000);
      send_code(6'd7, 32'hFFFF_FFFF);
      send_code(6'd0, 32'h0000_0000);
      // Whole bytes and full-width codes.
      send_code(6'd8, 32'h0000_00A5);
      send_code(6'd32, 32'hFFFF_FFFF);
      send_code(6'd32, 32'h0000_0000);
      send_code(6'd32, 32'h1234_5678);
      // A full-width code on top of pending bits gives four bytes.
      send_code(6'd3, 32'h0000_0005);
      send_code(6'd32, 32'hDEAD_BEEF);
      send_code(6'd0, 32'h0000_0000);
      // Lengths above the maximum are cut to the maximum.
      send_code(6'd33, 32'hCAFE_F00D);
      send_code(6'd63, 32'hFFFF_FFFF);
      send_code(6'd40, 32'h8000_0001);
      // Bits above the length must be ignored.
      send_code(6'd4, 32'hFFFF_FFF0);
      send_code(6'd4, 32'hFFFF_FFFA);
      send_code(6'd5, 32'hFFFF_FFE0);
      send_code(6'd1, 32'hFFFF_FFFE);
      send_code(6'd0, 32'h0000_0000);
      send_code(6'd6, 32'h0000_002D);
      send_code(6'd0, 32'h0000_0000);
      send_code(6'd0, 32'h0000_0000);
      drain_results();

      for (int n = 0; n < RANDOM_CODES; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            len = '0;
         end else if (pick < 18) begin
            len = CODE_LEN_W'($urandom_range(MAX_CODE_LEN_DEF + 1, 63));
         end else if (pick < 40) begin
            len = CODE_LEN_W'($urandom_range(25, MAX_CODE_LEN_DEF));
         end else begin
            len = CODE_LEN_W'($urandom_range(1, 24));
         end
         bits = $urandom();
         if (n % 97 == 96) drain_results();
         send_code(len, bits);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Sent %0d codes (%0d flushes, %0d with overlong lengths); %0d output bytes checked.",
               codes_sent, flushes_sent, overlong_sent, bytes_seen);
      if (mismatches == 0 && bytes_left == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #6_000_000;
      $display("Timeout with %0d bytes still expected.", bytes_left);
      $display("Regression FAIL");
      $finish;
   end

endmodule
